>>> rtl/core/lifegrid_pkg.sv
// Package for the life grid block: word types, request and register codes,
// the sequencer's control word and its microcode table. No dependencies.
`default_nettype none

package lifegrid_pkg;

   // Default grid limits handed to the top-level parameters.
   localparam int MAX_WIDTH_DEF  = 64;
   localparam int MAX_HEIGHT_DEF = 64;

   // Reset value of both dimension registers.
   localparam logic [6:0] GRID_DIM_RESET = 7'd64;

   // Request kinds.
   localparam logic [1:0] REQ_WRITE   = 2'd0;
   localparam logic [1:0] REQ_READ    = 2'd1;
   localparam logic [1:0] REQ_ADVANCE = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   // Microprogram step addresses.
   localparam logic [2:0] STEP_CLEAR    = 3'd0;
   localparam logic [2:0] STEP_IDLE     = 3'd1;
   localparam logic [2:0] STEP_CELL     = 3'd2;
   localparam logic [2:0] STEP_ADV_LOAD = 3'd3;
   localparam logic [2:0] STEP_ADV_ROW  = 3'd4;
   localparam logic [2:0] STEP_RESP     = 3'd5;

   // Jump conditions: when the condition holds the sequencer goes to
   // jump_step (STEP_ADV_LOAD for an advance at dispatch), else next_step.
   localparam logic [1:0] COND_ALWAYS    = 2'd0;
   localparam logic [1:0] COND_DISPATCH  = 2'd1;
   localparam logic [1:0] COND_CLR_LAST  = 2'd2;
   localparam logic [1:0] COND_ROW_LAST  = 2'd3;

   typedef struct packed {
      logic [1:0] req_type;
      logic [5:0] cell_row;
      logic [5:0] cell_column;
      logic       write_value;
   } req_word_type;

   typedef struct packed {
      logic read_value;
      logic coordinate_error;
   } rsp_word_type;

   // One control word per microprogram step.
   typedef struct packed {
      logic [2:0] next_step;
      logic [2:0] jump_step;
      logic [1:0] cond;
      logic       busy;
      logic       rsp;
      logic       clr_wr;
      logic       cell_op;
      logic       adv_load;
      logic       adv_row;
      logic       latch_req;
   } ctl_word_type;

   // Datapath status seen by the jump logic.
   typedef struct packed {
      logic clear_last;
      logic row_last;
      logic adv_request;
   } seq_status_type;

   // The microprogram. Fields: next, jump, cond, busy, rsp, clr_wr,
   // cell_op, adv_load, adv_row, latch_req.
   function automatic ctl_word_type micro_rom(input logic [2:0] step);
      ctl_word_type w;
      w = '{STEP_IDLE, STEP_IDLE, COND_ALWAYS, 1'b1, 1'b0, 1'b0, 1'b0,
            1'b0, 1'b0, 1'b0};
      unique case (step)
         STEP_CLEAR: begin
            w = '{STEP_CLEAR, STEP_IDLE, COND_CLR_LAST, 1'b1, 1'b0, 1'b1,
                  1'b0, 1'b0, 1'b0, 1'b0};
         end
         STEP_IDLE: begin
            w = '{STEP_IDLE, STEP_CELL, COND_DISPATCH, 1'b0, 1'b0, 1'b0,
                  1'b0, 1'b0, 1'b0, 1'b1};
         end
         STEP_CELL: begin
            w = '{STEP_IDLE, STEP_IDLE, COND_ALWAYS, 1'b1, 1'b1, 1'b0,
                  1'b1, 1'b0, 1'b0, 1'b0};
         end
         STEP_ADV_LOAD: begin
            w = '{STEP_ADV_ROW, STEP_ADV_ROW, COND_ALWAYS, 1'b1, 1'b0, 1'b0,
                  1'b0, 1'b1, 1'b0, 1'b0};
         end
         STEP_ADV_ROW: begin
            w = '{STEP_ADV_ROW, STEP_RESP, COND_ROW_LAST, 1'b1, 1'b0, 1'b0,
                  1'b0, 1'b0, 1'b1, 1'b0};
         end
         STEP_RESP: begin
            w = '{STEP_IDLE, STEP_IDLE, COND_ALWAYS, 1'b1, 1'b1, 1'b0,
                  1'b0, 1'b0, 1'b0, 1'b0};
         end
         default: begin
            // Unused step addresses fall back to idle.
            w = '{STEP_IDLE, STEP_IDLE, COND_ALWAYS, 1'b1, 1'b0, 1'b0,
                  1'b0, 1'b0, 1'b0, 1'b0};
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/lifegrid_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module lifegrid_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/core/lifegrid_seq.sv
// Microcoded sequencer: step counter, microcode table lookup and jump logic.
// Depends on lifegrid_pkg.
`default_nettype none

module lifegrid_seq (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire lifegrid_pkg::seq_status_type status,
   output lifegrid_pkg::ctl_word_type      ctl
);

   logic [2:0] step_ff;
   logic [2:0] step_in;

   assign ctl = lifegrid_pkg::micro_rom(step_ff);

   // Pick the next step from the control word's condition.
   always_comb begin
      step_in = ctl.next_step;
      unique case (ctl.cond)
         lifegrid_pkg::COND_ALWAYS: begin
            step_in = ctl.jump_step;
         end
         lifegrid_pkg::COND_DISPATCH: begin
            // An accepted request enters the cell routine or the advance routine.
            if (start) begin
               step_in = status.adv_request ? lifegrid_pkg::STEP_ADV_LOAD
                                            : ctl.jump_step;
            end
         end
         lifegrid_pkg::COND_CLR_LAST: begin
            if (status.clear_last) begin
               step_in = ctl.jump_step;
            end
         end
         lifegrid_pkg::COND_ROW_LAST: begin
            if (status.row_last) begin
               step_in = ctl.jump_step;
            end
         end
      endcase
   end

   // Reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= lifegrid_pkg::STEP_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/lifegrid_dp.sv
// Datapath: grid RAM, row counter, old-generation row buffers, the B3/S23
// row rule and the cell read/write logic. Depends on lifegrid_pkg and
// lifegrid_ram.
`default_nettype none

module lifegrid_dp #(
   parameter int MAX_WIDTH  = lifegrid_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = lifegrid_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lifegrid_pkg::ctl_word_type  ctl,
   input  wire lifegrid_pkg::req_word_type  req_word,
   input  wire logic [6:0]                  grid_width,
   input  wire logic [6:0]                  grid_height,
   output lifegrid_pkg::seq_status_type     status,
   output logic                             rsp_strobe,
   output lifegrid_pkg::rsp_word_type       rsp_word
);

   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
   localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);
   localparam logic [WCNT_W-1:0] W_MAX     = WCNT_W'(MAX_WIDTH);
   localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(MAX_HEIGHT - 1);
   localparam logic [MAX_WIDTH-1:0] ROW_ONES = {MAX_WIDTH{1'b1}};
   localparam logic [MAX_WIDTH-1:0] ROW_ONE  = MAX_WIDTH'(1);

   lifegrid_pkg::req_word_type req_ff;
   lifegrid_pkg::rsp_word_type rsp_word_ff;
   lifegrid_pkg::rsp_word_type rsp_word_in;
   logic                       rsp_strobe_ff;
   logic [ROW_W-1:0]           cnt_ff;
   logic [ROW_W-1:0]           cnt_in;
   logic [MAX_WIDTH-1:0]       above_ff;
   logic [MAX_WIDTH-1:0]       cur_ff;

   logic [WCNT_W-1:0]          w_eff;
   logic [HCNT_W-1:0]          h_eff;
   logic [MAX_WIDTH-1:0]       mask;
   logic                       in_grid;
   logic [ROW_W:0]             cnt_plus2;

   logic                       wr_en;
   logic [ROW_W-1:0]           wr_addr;
   logic [MAX_WIDTH-1:0]       wr_data;
   logic [ROW_W-1:0]           rd_addr;
   logic [MAX_WIDTH-1:0]       rd_data;

   logic [MAX_WIDTH-1:0]       cur_m;
   logic [MAX_WIDTH-1:0]       below_m;
   logic [MAX_WIDTH-1:0]       fresh;
   logic [MAX_WIDTH-1:0]       cell_mask;
   logic [MAX_WIDTH-1:0]       cell_row_word;
   logic [MAX_WIDTH-1:0]       shifted;

   // Clamp the dimension registers into the legal range.
   always_comb begin
      if (grid_width == 7'd0) begin
         w_eff = WCNT_W'(1);
      end else if (32'(grid_width) > MAX_WIDTH) begin
         w_eff = W_MAX;
      end else begin
         w_eff = WCNT_W'(grid_width);
      end
      if (grid_height == 7'd0) begin
         h_eff = HCNT_W'(1);
      end else if (32'(grid_height) > MAX_HEIGHT) begin
         h_eff = HCNT_W'(MAX_HEIGHT);
      end else begin
         h_eff = HCNT_W'(grid_height);
      end
   end

   assign mask    = ROW_ONES >> (W_MAX - w_eff);
   assign in_grid = (32'(req_ff.cell_row) < 32'(h_eff)) &&
                    (32'(req_ff.cell_column) < 32'(w_eff));

   // Status for the jump logic.
   assign status.clear_last  = (cnt_ff == ROW_LAST);
   assign status.row_last    = ((32'(cnt_ff) + 1) == 32'(h_eff));
   assign status.adv_request = (req_word.req_type == lifegrid_pkg::REQ_ADVANCE);

   // Read address: the requested row (row 0 for an advance) while idle,
   // row 1 at the advance load, and two rows ahead during the row sweep.
   assign cnt_plus2 = {1'b0, cnt_ff} + (ROW_W + 1)'(2);
   always_comb begin
      rd_addr = '0;
      if (ctl.latch_req) begin
         if (req_word.req_type != lifegrid_pkg::REQ_ADVANCE) begin
            rd_addr = ROW_W'(req_word.cell_row);
         end
      end else if (ctl.adv_load) begin
         rd_addr = ROW_W'(1);
      end else if (ctl.adv_row) begin
         if (32'(cnt_plus2) < MAX_HEIGHT) begin
            rd_addr = cnt_plus2[ROW_W-1:0];
         end
      end
   end

   // B3/S23 rule over one row; columns outside the active area count as dead.
   assign cur_m   = cur_ff & mask;
   assign below_m = status.row_last ? '0 : (rd_data & mask);
   always_comb begin
      logic [MAX_WIDTH-1:0] a_l, a_r, c_l, c_r, b_l, b_r;
      logic [3:0]           n;
      a_l = above_ff << 1;
      a_r = above_ff >> 1;
      c_l = cur_m << 1;
      c_r = cur_m >> 1;
      b_l = below_m << 1;
      b_r = below_m >> 1;
      fresh = '0;
      for (int c = 0; c < MAX_WIDTH; c++) begin
         n = 4'(a_l[c]) + 4'(above_ff[c]) + 4'(a_r[c]) + 4'(c_l[c]) +
             4'(c_r[c]) + 4'(b_l[c]) + 4'(below_m[c]) + 4'(b_r[c]);
         fresh[c] = (n == 4'd3) || ((n == 4'd2) && cur_m[c]);
      end
      fresh = fresh & mask;
   end

   // Cell read and read-modify-write of the stored row.
   assign cell_mask = ROW_ONE << req_ff.cell_column;
   assign shifted   = rd_data >> req_ff.cell_column;
   assign cell_row_word = req_ff.write_value ? (rd_data | cell_mask)
                                             : (rd_data & ~cell_mask);

   // RAM write port.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff;
      wr_data = '0;
      if (ctl.clr_wr) begin
         wr_en = 1'b1;
      end else if (ctl.adv_row) begin
         wr_en   = 1'b1;
         wr_data = (cur_ff & ~mask) | fresh;
      end else if (ctl.cell_op) begin
         wr_en   = (req_ff.req_type == lifegrid_pkg::REQ_WRITE) && in_grid;
         wr_addr = ROW_W'(req_ff.cell_row);
         wr_data = cell_row_word;
      end
   end

   lifegrid_ram #(
      .WIDTH (MAX_WIDTH),
      .DEPTH (MAX_HEIGHT)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Result word for the cell routine; an advance answers with zeros.
   always_comb begin
      rsp_word_in = '0;
      if (ctl.cell_op) begin
         unique case (req_ff.req_type)
            lifegrid_pkg::REQ_WRITE: begin
               rsp_word_in.coordinate_error = !in_grid;
            end
            lifegrid_pkg::REQ_READ: begin
               rsp_word_in.coordinate_error = !in_grid;
               rsp_word_in.read_value       = in_grid && shifted[0];
            end
            default: begin
               rsp_word_in = '0;
            end
         endcase
      end
   end

   // Row counter for the clearing pass and the generation sweep.
   always_comb begin
      cnt_in = cnt_ff;
      if (ctl.adv_load) begin
         cnt_in = '0;
      end else if (ctl.clr_wr || ctl.adv_row) begin
         cnt_in = cnt_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= ctl.rsp;
      end
   end

   // Request latch, result register and old-generation row buffers.
   always_ff @(posedge clock) begin
      if (ctl.latch_req) begin
         req_ff <= req_word;
      end
      if (ctl.rsp) begin
         rsp_word_ff <= rsp_word_in;
      end
      if (ctl.adv_load) begin
         above_ff <= '0;
         cur_ff   <= rd_data;
      end else if (ctl.adv_row) begin
         above_ff <= cur_m;
         cur_ff   <= rd_data;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

`default_nettype wire

>>> rtl/core/life_cellular_automaton_grid.sv
// Top level of the life grid: configuration registers, sequencer and datapath.
// Depends on lifegrid_pkg, lifegrid_seq and lifegrid_dp.
//
//   channel   ports                                    handshake
//   request   start, busy, req_word                    start && !busy
//   result    rsp_strobe, rsp_word                     strobe, one cycle
//   config    csr_write_enable, csr_index, csr_write_data   write enable
//
// A cell read or write runs the cell step, whose result word is registered
// into rsp_word with the strobe; a new word is taken only back in idle. An
// advance loads row 0 and then sweeps every row of the clamped height, one
// row word per cycle through the grid RAM's single read port, then answers.
// After reset a clearing pass writes every row dead, with busy high; configuration
// writes are taken during it. Results cannot be stalled by the receiver.
`default_nettype none

module life_cellular_automaton_grid #(
   parameter int MAX_WIDTH  = lifegrid_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = lifegrid_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire lifegrid_pkg::req_word_type req_word,
   output logic                            rsp_strobe,
   output lifegrid_pkg::rsp_word_type      rsp_word,
   input  wire logic                       csr_write_enable,
   input  wire logic                       csr_index,
   input  wire logic [6:0]                 csr_write_data
);

   logic [6:0]                  grid_width_ff;
   logic [6:0]                  grid_height_ff;
   lifegrid_pkg::ctl_word_type  ctl;
   lifegrid_pkg::seq_status_type status;

   // Dimension registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= lifegrid_pkg::GRID_DIM_RESET;
         grid_height_ff <= lifegrid_pkg::GRID_DIM_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lifegrid_pkg::CSR_GRID_WIDTH:  grid_width_ff  <= csr_write_data;
            lifegrid_pkg::CSR_GRID_HEIGHT: grid_height_ff <= csr_write_data;
         endcase
      end
   end

   lifegrid_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctl    (ctl)
   );

   lifegrid_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .req_word    (req_word),
      .grid_width  (grid_width_ff),
      .grid_height (grid_height_ff),
      .status      (status),
      .rsp_strobe  (rsp_strobe),
      .rsp_word    (rsp_word)
   );

   assign busy = ctl.busy;

`ifndef SYNTHESIS
   // An accepted word always makes the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a word");

   // A cell read or write answers through the cell step and the strobe register.
   a_cell_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_word.req_type != lifegrid_pkg::REQ_ADVANCE))
      |-> ##2 rsp_strobe)
      else $error("cell result word missing");

   // Result strobes never come in adjacent cycles.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");
`endif

endmodule

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the life grid: drives cell reads, writes and
// generation steps, and checks every result word against its own grid tracker.
// Depends on lifegrid_pkg and life_cellular_automaton_grid.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Request code the block leaves unused.
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int         GRID_ROWS  = 64;
   localparam int         GRID_COLS  = 64;
   localparam int         MAX_PRINTS = 100;

   // Tracks the grid and dimension registers, and the result words still owed.
   class grid_tracker;
      logic [GRID_COLS-1:0]       row_words [GRID_ROWS];
      logic [6:0]                 width_reg;
      logic [6:0]                 height_reg;
      lifegrid_pkg::rsp_word_type pending_rsp_words [$];
      int                         mismatches;
      int                         checked_words;

      function new();
         foreach (row_words[i]) row_words[i] = '0;
         width_reg     = lifegrid_pkg::GRID_DIM_RESET;
         height_reg    = lifegrid_pkg::GRID_DIM_RESET;
         mismatches    = 0;
         checked_words = 0;
      endfunction

      // Out-of-range dimensions are pulled back into 1..64.
      function int clamp_dim(logic [6:0] v);
         if (v == 7'd0) return 1;
         if (v > 7'd64) return 64;
         return int'(v);
      endfunction

      function int cols_in_use();
         return clamp_dim(width_reg);
      endfunction

      function int rows_in_use();
         return clamp_dim(height_reg);
      endfunction

      function void write_reg(logic idx, logic [6:0] v);
         if (idx == lifegrid_pkg::CSR_GRID_WIDTH) width_reg = v;
         else height_reg = v;
      endfunction

      // One B3/S23 generation over the active area; cells outside it count
      // as dead and keep their stored values.
      function void step_generation();
         logic [GRID_COLS-1:0] old_rows [GRID_ROWS];
         logic [GRID_COLS-1:0] mask;
         logic [GRID_COLS-1:0] above;
         logic [GRID_COLS-1:0] cur;
         logic [GRID_COLS-1:0] below;
         logic [GRID_COLS-1:0] fresh;
         int                   w;
         int                   h;
         int                   n;
         logic                 alive;
         w = cols_in_use();
         h = rows_in_use();
         mask = (w >= GRID_COLS) ? '1 : ((64'd1 << w) - 64'd1);
         for (int r = 0; r < GRID_ROWS; r++) old_rows[r] = row_words[r] & mask;
         for (int r = 0; r < h; r++) begin
            above = (r > 0) ? old_rows[r-1] : '0;
            cur   = old_rows[r];
            below = (r + 1 < h) ? old_rows[r+1] : '0;
            fresh = '0;
            for (int c = 0; c < w; c++) begin
               n = int'(above[c]) + int'(below[c]);
               if (c > 0) n += int'(above[c-1]) + int'(cur[c-1]) + int'(below[c-1]);
               if (c + 1 < w) n += int'(above[c+1]) + int'(cur[c+1]) + int'(below[c+1]);
               alive = cur[c];
               if (n == 3) alive = 1'b1;
               else if (n != 2) alive = 1'b0;
               fresh[c] = alive;
            end
            row_words[r] = (row_words[r] & ~mask) | fresh;
         end
      endfunction

      // Applies one accepted request word and queues the result it owes.
      function void note_request(lifegrid_pkg::req_word_type word);
         lifegrid_pkg::rsp_word_type exp_word;
         logic                       in_area;
         exp_word = '0;
         in_area  = (int'(word.cell_row) < rows_in_use()) &&
                    (int'(word.cell_column) < cols_in_use());
         case (word.req_type)
            lifegrid_pkg::REQ_WRITE: begin
               if (in_area) row_words[word.cell_row][word.cell_column] = word.write_value;
               else exp_word.coordinate_error = 1'b1;
            end
            lifegrid_pkg::REQ_READ: begin
               if (in_area) exp_word.read_value = row_words[word.cell_row][word.cell_column];
               else exp_word.coordinate_error = 1'b1;
            end
            lifegrid_pkg::REQ_ADVANCE: begin
               step_generation();
            end
            default: begin
               // The unused code changes nothing and answers with zeros.
            end
         endcase
         pending_rsp_words.push_back(exp_word);
      endfunction

      task report_mismatch(string msg);
         if (mismatches < MAX_PRINTS) $display("tb: mismatch: %s", msg);
         mismatches++;
      endtask

      // Compares one result word with the oldest one owed.
      task check_rsp(lifegrid_pkg::rsp_word_type got);
         lifegrid_pkg::rsp_word_type want;
         if (pending_rsp_words.size() == 0) begin
            report_mismatch("result word with no request waiting");
            return;
         end
         want = pending_rsp_words.pop_front();
         if (got.read_value !== want.read_value)
            report_mismatch($sformatf("word %0d read_value %b, wanted %b",
                                      checked_words, got.read_value, want.read_value));
         if (got.coordinate_error !== want.coordinate_error)
            report_mismatch($sformatf("word %0d coordinate_error %b, wanted %b",
                                      checked_words, got.coordinate_error,
                                      want.coordinate_error));
         checked_words++;
      endtask

      task check_drained();
         if (pending_rsp_words.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived",
                                      pending_rsp_words.size()));
      endtask
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   lifegrid_pkg::req_word_type req_word = '0;
   logic                       rsp_strobe;
   lifegrid_pkg::rsp_word_type rsp_word;
   logic                       csr_write_enable = 1'b0;
   logic                       csr_index = 1'b0;
   logic [6:0]                 csr_write_data = '0;

   grid_tracker  sb;
   int           idle_pct = 6;
   int           items_sent = 0;

   life_cellular_automaton_grid u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_word         (req_word),
      .rsp_strobe       (rsp_strobe),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Every strobed result word goes to the tracker.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_rsp(rsp_word);
   end

   function automatic lifegrid_pkg::req_word_type make_req(logic [1:0] kind, int row,
                                                           int col, logic value);
      lifegrid_pkg::req_word_type word;
      word.req_type    = kind;
      word.cell_row    = row[5:0];
      word.cell_column = col[5:0];
      word.write_value = value;
      return word;
   endfunction

   // A coordinate near a center, kept inside the area; now and then anywhere.
   function automatic int near(int center, int limit);
      int v;
      if ($urandom_range(9) == 0) return $urandom_range(63);
      v = center + int'($urandom_range(4)) - 2;
      if (v < 0) v = 0;
      if (v > limit - 1) v = limit - 1;
      return v;
   endfunction

   // Dimension value: often an extreme, otherwise anything in range.
   function automatic logic [6:0] pick_dim();
      logic [6:0] extremes [8];
      extremes = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd63, 7'd64, 7'd65, 7'd127};
      if ($urandom_range(9) < 4) return extremes[$urandom_range(7)];
      return 7'($urandom_range(1, 64));
   endfunction

   // Offers one request word after a random idle gap and waits for acceptance.
   task automatic send_word(lifegrid_pkg::req_word_type word);
      int gap;
      gap = 0;
      while (gap < 24 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= word;
      do @(posedge clock); while (busy);
      sb.note_request(word);
      items_sent++;
   endtask

   // Stops offering words and waits until every owed result has come.
   task automatic drain();
      start <= 1'b0;
      while (sb.pending_rsp_words.size() != 0) @(posedge clock);
   endtask

   // Writes both dimension registers on back-to-back cycles.
   task automatic set_grid(logic [6:0] cols, logic [6:0] rows);
      csr_write_enable <= 1'b1;
      csr_index        <= lifegrid_pkg::CSR_GRID_WIDTH;
      csr_write_data   <= cols;
      @(posedge clock);
      sb.write_reg(lifegrid_pkg::CSR_GRID_WIDTH, cols);
      csr_index        <= lifegrid_pkg::CSR_GRID_HEIGHT;
      csr_write_data   <= rows;
      @(posedge clock);
      sb.write_reg(lifegrid_pkg::CSR_GRID_HEIGHT, rows);
      csr_write_enable <= 1'b0;
   endtask

   // A seeded cluster of writes, a few generations, then reads around it.
   task automatic run_episode();
      int w;
      int h;
      int cr;
      int cc;
      w  = sb.cols_in_use();
      h  = sb.rows_in_use();
      cr = $urandom_range(h - 1);
      cc = $urandom_range(w - 1);
      repeat ($urandom_range(2, 12))
         send_word(make_req(lifegrid_pkg::REQ_WRITE, near(cr, h), near(cc, w),
                            $urandom_range(3) != 0));
      repeat ($urandom_range(3))
         send_word(make_req(lifegrid_pkg::REQ_ADVANCE, $urandom_range(63),
                            $urandom_range(63), 1'($urandom_range(1))));
      repeat ($urandom_range(1, 6))
         send_word(make_req(lifegrid_pkg::REQ_READ, near(cr, h), near(cc, w),
                            1'($urandom_range(1))));
      // Occasional noise word of any kind, anywhere.
      if ($urandom_range(7) == 0)
         send_word(make_req(2'($urandom_range(3)), $urandom_range(63), $urandom_range(63),
                            1'($urandom_range(1))));
   endtask

   initial begin
      int target;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed words on the full 64 x 64 grid: corners, unused code, a blinker.
      send_word(make_req(lifegrid_pkg::REQ_READ, 0, 0, 1'b0));
      send_word(make_req(lifegrid_pkg::REQ_WRITE, 0, 0, 1'b1));
      send_word(make_req(lifegrid_pkg::REQ_READ, 0, 0, 1'b0));
      send_word(make_req(lifegrid_pkg::REQ_WRITE, 63, 63, 1'b1));
      send_word(make_req(lifegrid_pkg::REQ_READ, 63, 63, 1'b1));
      send_word(make_req(lifegrid_pkg::REQ_WRITE, 0, 63, 1'b1));
      send_word(make_req(lifegrid_pkg::REQ_WRITE, 63, 0, 1'b1));
      send_word(make_req(REQ_UNUSED, 63, 63, 1'b1));
      send_word(make_req(lifegrid_pkg::REQ_WRITE, 31, 30, 1'b1));
      send_word(make_req(lifegrid_pkg::REQ_WRITE, 31, 31, 1'b1));
      send_word(make_req(lifegrid_pkg::REQ_WRITE, 31, 32, 1'b1));
      send_word(make_req(lifegrid_pkg::REQ_ADVANCE, 0, 0, 1'b0));
      send_word(make_req(lifegrid_pkg::REQ_READ, 30, 31, 1'b0));
      send_word(make_req(lifegrid_pkg::REQ_READ, 31, 30, 1'b0));
      send_word(make_req(lifegrid_pkg::REQ_ADVANCE, 63, 63, 1'b1));
      send_word(make_req(lifegrid_pkg::REQ_READ, 31, 30, 1'b0));
      send_word(make_req(lifegrid_pkg::REQ_WRITE, 0, 0, 1'b0));

      // Zero width acts as one column; an oversized height as 64 rows.
      drain();
      set_grid(7'd0, 7'd127);
      send_word(make_req(lifegrid_pkg::REQ_READ, 5, 1, 1'b0));
      send_word(make_req(lifegrid_pkg::REQ_WRITE, 5, 1, 1'b1));
      send_word(make_req(lifegrid_pkg::REQ_WRITE, 5, 0, 1'b1));
      send_word(make_req(lifegrid_pkg::REQ_ADVANCE, 0, 0, 1'b0));

      // Oversized width, zero height: a single 64-cell row.
      drain();
      set_grid(7'd127, 7'd0);
      send_word(make_req(lifegrid_pkg::REQ_READ, 1, 0, 1'b0));
      send_word(make_req(lifegrid_pkg::REQ_WRITE, 0, 63, 1'b1));
      send_word(make_req(lifegrid_pkg::REQ_ADVANCE, 0, 0, 1'b0));
      send_word(make_req(lifegrid_pkg::REQ_READ, 0, 63, 1'b0));

      // Random episodes in three idle regimes, several grid sizes in each.
      for (int regime = 0; regime < 3; regime++) begin
         idle_pct = (regime == 0) ? 6 : ((regime == 1) ? 69 : 0);
         for (int phase = 0; phase < 4; phase++) begin
            drain();
            set_grid(pick_dim(), pick_dim());
            target = items_sent + 70;
            while (items_sent < target) run_episode();
         end
      end

      drain();
      repeat (8) @(posedge clock);
      sb.check_drained();
      if (sb.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

endmodule
